[rtl/smcs_pkg.sv]
package smcs_pkg;

    localparam int MaxVocab  = 131072;
    localparam int IdxW      = $clog2(MaxVocab);
    localparam int CntW      = $clog2(MaxVocab + 1);
    localparam int LogitW    = 24;
    localparam int WeightW   = 17;
    localparam int TotalW    = 34;
    localparam logic [63:0] SeedReset = 64'd88172645463325252;
    localparam logic signed [LogitW-1:0] LogitMin = {1'b1, {(LogitW-1){1'b0}}};
    localparam logic [12:0] Log2eQ12 = 13'd5909;

    typedef struct packed {
        logic signed [LogitW-1:0] logit_value;
        logic                     is_last;
    } t_in_item;

    typedef struct packed {
        logic [16:0] token_index;
        logic        overflow_flag;
    } t_out_item;

    function automatic logic [16:0] pow2_tab(input logic [4:0] k);
        logic [16:0] v;
        unique case (k)
            5'd0:  v = 17'd65536;
            5'd1:  v = 17'd62757;
            5'd2:  v = 17'd60097;
            5'd3:  v = 17'd57549;
            5'd4:  v = 17'd55109;
            5'd5:  v = 17'd52773;
            5'd6:  v = 17'd50535;
            5'd7:  v = 17'd48393;
            5'd8:  v = 17'd46341;
            5'd9:  v = 17'd44376;
            5'd10: v = 17'd42495;
            5'd11: v = 17'd40693;
            5'd12: v = 17'd38968;
            5'd13: v = 17'd37316;
            5'd14: v = 17'd35734;
            5'd15: v = 17'd34219;
            default: v = 17'd32768;
        endcase
        return v;
    endfunction

endpackage

[rtl/softmax_categorical_sampler_core.sv]
// Softmax categorical sampler.
// Input: one logit beat (t_in_item) is taken on a clock edge with i_start high
// and o_busy low. Logits load at one per cycle into the logit memory while the
// running maximum is tracked. The beat with is_last closes the vector.
// After closing, the block is busy for two passes over the N stored entries
// (N = logits kept, at most MaxVocab): a weight pass that writes exp(logit -
// max) into the weight memory and sums it, a threshold step (xorshift64
// step, then a 53x34 product split in 32-bit pieces), and a search pass that
// stops at the first running sum above the threshold.
// Output: o_res_valid is high for exactly one cycle with o_res; the receiver
// cannot stall it. Logits beyond capacity are dropped and flag overflow.
// Seed: i_cfg_valid/o_cfg_ready write the seed register at any time; the value
// also loads the generator only while no vector is being collected.
// Reset sets state, count, maximum, sum, drop flag, valid and seed; memories
// hold undefined data; only entries written in the current vector are read.
module softmax_categorical_sampler_core import smcs_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_start,
    output logic      o_busy,
    input  t_in_item  i_item,
    output logic      o_res_valid,
    output t_out_item o_res,
    input  logic      i_cfg_valid,
    output logic      o_cfg_ready,
    input  logic [63:0] i_cfg_data
);

    typedef enum logic [4:0] {
        S_LOAD = 5'b00001,
        S_WGT  = 5'b00010,
        S_THR  = 5'b00100,
        S_SRCH = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

    t_state r_state, n_state;

    logic signed [LogitW-1:0] logit_mem [MaxVocab];
    logic [WeightW-1:0]       weight_mem [MaxVocab];

    logic signed [LogitW-1:0] r_max;
    logic [CntW-1:0]          r_count;
    logic [TotalW-1:0]        r_total;
    logic [63:0]              r_gen, r_seed;
    logic                     r_drop;

    // pass pipeline: address issue, read data, weight compute
    logic [CntW-1:0]          r_addr;
    logic                     r_v1, r_v2;
    logic [IdxW-1:0]          r_a1, r_a2;
    logic signed [LogitW-1:0] r_lrd;
    logic [WeightW-1:0]       r_wrd;
    logic [31:0]              r_e;
    logic                     r_ez;
    logic [TotalW-1:0]        r_acc, r_thr;
    logic [IdxW-1:0]          r_tok;
    logic [2:0]               r_tstep;
    logic [63:0]              r_p1, r_p2, r_p3, r_p4;

    wire accept = i_start && !o_busy;
    assign o_busy      = (r_state != S_LOAD);
    assign o_cfg_ready = 1'b1;

    // memory ports
    always_ff @(posedge i_clk) begin
        if (accept && r_count < CntW'(MaxVocab))
            logit_mem[r_count[IdxW-1:0]] <= i_item.logit_value;
        r_lrd <= logit_mem[r_addr[IdxW-1:0]];
    end

    // weight stage: diff and scale
    logic signed [LogitW:0] d;
    logic [LogitW:0]        nd;
    logic [38:0]            eprod;
    assign d     = (LogitW+1)'(r_lrd) - (LogitW+1)'(r_max);
    assign nd    = -d;
    assign eprod = 39'(nd) * 39'(Log2eQ12);

    logic [16:0] t0, t1, m;
    logic [4:0]  kk;
    logic [24:0] dm;
    logic [WeightW-1:0] w;
    assign kk = {1'b0, r_e[11:8]};
    assign t0 = pow2_tab(kk);
    assign t1 = pow2_tab(kk + 5'd1);
    assign dm = 25'(t0 - t1) * 25'(r_e[7:0]);
    assign m  = t0 - 17'(dm >> 8);
    always_comb begin
        if (r_ez || r_e[31:12] >= 20'd17) w = '0;
        else w = WeightW'(m >> r_e[16:12]);
    end

    logic [63:0] x1, x2, x3, xa;
    assign x1 = r_gen ^ (r_gen << 13);
    assign x2 = x1 ^ (x1 >> 7);
    assign x3 = x2 ^ (x2 << 17);
    assign xa = r_gen >> 11;

    logic [TotalW-1:0] acc_nx;
    assign acc_nx = r_acc + TotalW'(r_wrd);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_max   <= LogitMin;
            r_count <= '0;
            r_total <= '0;
            r_drop  <= 1'b0;
            r_seed  <= SeedReset;
            r_gen   <= SeedReset;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            o_res_valid <= 1'b0;
        end else begin
            o_res_valid <= 1'b0;
            if (i_cfg_valid) begin
                r_seed <= i_cfg_data;
                if (r_count == '0 && r_state == S_LOAD) r_gen <= i_cfg_data;
            end
            unique case (r_state)
                S_LOAD: if (accept) begin
                    if (r_count < CntW'(MaxVocab)) begin
                        r_count <= r_count + 1'b1;
                        if (i_item.logit_value > r_max) r_max <= i_item.logit_value;
                    end else r_drop <= 1'b1;
                    if (i_item.is_last) begin
                        r_state <= S_WGT;
                        r_addr  <= '0;
                        r_total <= '0;
                        r_v1    <= 1'b0;
                        r_v2    <= 1'b0;
                    end
                end
                S_WGT: begin
                    // advance address; stage1 = read, stage2 = log2 scale
                    r_v1 <= (r_addr < r_count);
                    r_a1 <= r_addr[IdxW-1:0];
                    if (r_addr < r_count) r_addr <= r_addr + 1'b1;
                    r_v2 <= r_v1;
                    r_a2 <= r_a1;
                    r_ez <= (d < -(LogitW+1)'(65536));
                    r_e  <= 32'(eprod >> 12);
                    if (r_v2) r_total <= r_total + TotalW'(w);
                    if (!r_v1 && !r_v2 && r_addr == r_count) begin
                        r_state <= S_THR;
                        r_tstep <= '0;
                    end
                end
                S_THR: begin
                    r_tstep <= r_tstep + 1'b1;
                    unique case (r_tstep)
                        3'd0: r_gen <= x3;
                        3'd1: begin
                            r_p1 <= 64'(xa[31:0]) * 64'(r_total[31:0]);
                            r_p2 <= 64'(xa[52:32]) * 64'(r_total[31:0]);
                            r_p3 <= 64'(xa[31:0]) * 64'(r_total[33:32]);
                            r_p4 <= 64'(xa[52:32]) * 64'(r_total[33:32]);
                        end
                        3'd2: r_p2 <= r_p2 + r_p3 + (r_p1 >> 32);
                        default: begin
                            r_thr   <= TotalW'((r_p4 << 11) + (r_p2 >> 21));
                            r_state <= S_SRCH;
                            r_addr  <= '0;
                            r_acc   <= '0;
                            r_tok   <= '0;
                            r_v1    <= 1'b0;
                        end
                    endcase
                end
                S_SRCH: begin
                    r_v1 <= (r_addr < r_count);
                    r_a1 <= r_addr[IdxW-1:0];
                    if (r_addr < r_count) r_addr <= r_addr + 1'b1;
                    if (r_v1) begin
                        r_acc <= acc_nx;
                        if (acc_nx > r_thr) begin
                            r_tok   <= r_a1;
                            r_state <= S_OUT;
                        end
                    end
                    if (!r_v1 && r_addr == r_count) r_state <= S_OUT;
                end
                S_OUT: begin
                    o_res_valid <= 1'b1;
                    o_res.token_index   <= 17'(r_tok);
                    o_res.overflow_flag <= r_drop;
                    r_state <= S_LOAD;
                    r_max   <= LogitMin;
                    r_count <= '0;
                    r_total <= '0;
                    r_drop  <= 1'b0;
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_WGT && r_v2) weight_mem[r_a2] <= w;
        r_wrd <= weight_mem[r_addr[IdxW-1:0]];
    end

    assign n_state = r_state;

    property p_no_load_busy;
        @(posedge i_clk) disable iff (!i_rst_n) o_busy |-> !accept;
    endproperty
    a_no_load_busy: assert property (p_no_load_busy) else $error("accept while busy");

    a_out_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |=> !o_res_valid) else $error("result held two cycles");

    a_out_from: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> $past(n_state == S_OUT)) else $error("result outside out state");

    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CntW'(MaxVocab)) else $error("count above capacity");

    a_thr_below: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SRCH && r_total != '0) |-> r_thr < r_total)
        else $error("threshold not below total");

endmodule
